// ===== hdl/bsfm_pkg.sv =====
`default_nettype none
package bsfm_pkg;

    localparam int MAX_NEEDLE   = 16;
    localparam int MAX_HAYSTACK = 65536;

    localparam int BYTE_W    = 8;
    localparam int CNT_W     = $clog2(MAX_NEEDLE + 1);
    localparam int HAY_POS_W = $clog2(MAX_HAYSTACK + 2);
    localparam int CMP_W     = (HAY_POS_W > CNT_W) ? HAY_POS_W : CNT_W;
    localparam int IDX_W     = 17;
    localparam int STATUS_W  = 2;

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 24;

    localparam logic REQ_NEEDLE = 1'b0;
    localparam logic REQ_HAY    = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NEEDLE_LONG = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_HAY_LONG    = 2'd2;

    typedef logic [BYTE_W-1:0] byte_t;

    typedef struct packed {
        logic needle_shift;
        logic needle_clear;
        logic window_shift;
    } cell_ctrl_t;

    function automatic logic [IDX_W-1:0] to_index(input logic [HAY_POS_W-1:0] v);
        logic [HAY_POS_W+IDX_W-1:0] wide;
        wide = {{IDX_W{1'b0}}, v};
        return wide[IDX_W-1:0];
    endfunction

endpackage
`default_nettype wire

// ===== hdl/bsfm_cell.sv =====
`default_nettype none
module bsfm_cell (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire bsfm_pkg::cell_ctrl_t ctrl,
    input  wire bsfm_pkg::byte_t     needle_in,
    input  wire logic                occ_in,
    input  wire bsfm_pkg::byte_t     window_in,
    output bsfm_pkg::byte_t          needle_out,
    output logic                     occ_out,
    output bsfm_pkg::byte_t          window_out,
    output logic                     hit
);
    import bsfm_pkg::*;

    byte_t needle_reg;
    byte_t window_reg;
    logic  occ_reg;
    logic  occ_next;

    always_comb begin
        occ_next = occ_reg;
        if (ctrl.needle_shift) begin
            occ_next = occ_in;
        end else if (ctrl.needle_clear) begin
            occ_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= 1'b0;
        end else begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.needle_shift) begin
            needle_reg <= needle_in;
        end
        if (ctrl.window_shift) begin
            window_reg <= window_in;
        end
    end

    // compare against the byte that enters on this shift
    assign hit        = !occ_reg || (needle_reg == window_in);
    assign needle_out = needle_reg;
    assign occ_out    = occ_reg;
    assign window_out = window_reg;

endmodule
`default_nettype wire

// ===== hdl/byte_substring_first_match.sv =====
// Latency: a result is registered on m_tdata in the cycle after the haystack's last transaction.
// Throughput: one transaction per cycle while s_tready is high, needle or haystack; the window compare
// across the row of byte cells completes in the cycle of each haystack byte.
// The output register frees s_tready whenever the held result is taken.
// Reset (aresetn low, synchronous) clears the needle length, haystack position,
// match state and output valid.
`default_nettype none
module byte_substring_first_match (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // [7:0] data_byte, [8] has_byte, [15:9] zero
    input  wire logic [bsfm_pkg::S_TDATA_W-1:0] s_tdata,
    // [0] req_type
    input  wire logic                           s_tuser,
    input  wire logic                           s_tlast,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // [0] found, [17:1] match_index, [19:18] status, [23:20] zero
    output logic [bsfm_pkg::M_TDATA_W-1:0]      m_tdata
);
    import bsfm_pkg::*;

    localparam logic [HAY_POS_W-1:0] HAY_LIMIT = HAY_POS_W'(MAX_HAYSTACK);
    localparam logic [CNT_W-1:0]     CNT_LIMIT = CNT_W'(MAX_NEEDLE);

    logic  s_fire;
    logic  req_type;
    byte_t data_byte;
    logic  has_byte;

    logic [CNT_W-1:0]     count_reg, count_next, count_base;
    logic                 ovf_reg, ovf_next, ovf_base;
    logic                 open_reg, open_next;
    logic [HAY_POS_W-1:0] pos_reg, pos_next, pos_step;
    logic                 seen_reg, seen_next, seen_step;
    logic [HAY_POS_W-1:0] offset_reg, offset_next, offset_step;
    logic [CMP_W-1:0]     offset_wide;

    logic                 m_valid_reg, m_valid_next;
    logic                 found_reg, found_next;
    logic [IDX_W-1:0]     index_reg, index_next;
    logic [STATUS_W-1:0]  status_reg, status_next;
    logic                 result_load;

    cell_ctrl_t           ctrl;
    byte_t                needle_chain [MAX_NEEDLE];
    byte_t                window_chain [MAX_NEEDLE];
    logic [MAX_NEEDLE-1:0] occ_chain;
    logic [MAX_NEEDLE-1:0] hit_vec;

    assign s_tready  = !m_valid_reg || m_tready;
    assign s_fire    = s_tvalid && s_tready;
    assign req_type  = s_tuser;
    assign data_byte = s_tdata[BYTE_W-1:0];
    assign has_byte  = s_tdata[BYTE_W];

    genvar j;
    generate
        for (j = 0; j < MAX_NEEDLE; j++) begin : g_cell
            byte_t needle_src;
            byte_t window_src;
            logic  occ_src;
            if (j == 0) begin : g_head
                assign needle_src = data_byte;
                assign window_src = data_byte;
                assign occ_src    = 1'b1;
            end else begin : g_body
                assign needle_src = needle_chain[j-1];
                assign window_src = window_chain[j-1];
                assign occ_src    = occ_chain[j-1] && !ctrl.needle_clear;
            end
            bsfm_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .ctrl       (ctrl),
                .needle_in  (needle_src),
                .occ_in     (occ_src),
                .window_in  (window_src),
                .needle_out (needle_chain[j]),
                .occ_out    (occ_chain[j]),
                .window_out (window_chain[j]),
                .hit        (hit_vec[j])
            );
        end
    endgenerate

    always_comb begin
        count_base  = open_reg ? count_reg : '0;
        ovf_base    = open_reg ? ovf_reg : 1'b0;
        pos_step    = (pos_reg <= HAY_LIMIT) ? pos_reg + 1'b1 : pos_reg;
        offset_wide = CMP_W'(pos_step) - CMP_W'(count_reg);
        offset_step = offset_wide[HAY_POS_W-1:0];
        seen_step   = !seen_reg && (pos_step <= HAY_LIMIT) && (count_reg != '0)
                      && (CMP_W'(pos_step) >= CMP_W'(count_reg)) && (&hit_vec);
    end

    always_comb begin
        ctrl         = '0;
        count_next   = count_reg;
        ovf_next     = ovf_reg;
        open_next    = open_reg;
        pos_next     = pos_reg;
        seen_next    = seen_reg;
        offset_next  = offset_reg;
        result_load  = 1'b0;
        found_next   = 1'b0;
        index_next   = '0;
        status_next  = STATUS_OK;
        if (s_fire) begin
            if (req_type == REQ_NEEDLE) begin
                ctrl.needle_clear = !open_reg;
                count_next  = count_base;
                ovf_next    = ovf_base;
                pos_next    = '0;
                seen_next   = 1'b0;
                offset_next = '0;
                if (has_byte) begin
                    if (count_base < CNT_LIMIT) begin
                        ctrl.needle_shift = 1'b1;
                        count_next = count_base + 1'b1;
                    end else begin
                        ovf_next = 1'b1;
                    end
                end
                open_next = !s_tlast;
            end else begin
                open_next = 1'b0;
                if (has_byte) begin
                    ctrl.window_shift = 1'b1;
                    pos_next = pos_step;
                    if (seen_step) begin
                        seen_next   = 1'b1;
                        offset_next = offset_step;
                    end
                end
                if (s_tlast) begin
                    result_load = 1'b1;
                    if (ovf_reg) begin
                        status_next = STATUS_NEEDLE_LONG;
                        index_next  = to_index((pos_next > HAY_LIMIT) ? HAY_LIMIT : pos_next);
                    end else if (pos_next > HAY_LIMIT) begin
                        status_next = STATUS_HAY_LONG;
                        index_next  = to_index(HAY_LIMIT);
                    end else if (count_reg == '0) begin
                        found_next  = 1'b1;
                    end else if (seen_next) begin
                        found_next  = 1'b1;
                        index_next  = to_index(offset_next);
                    end else begin
                        index_next  = to_index(pos_next);
                    end
                    pos_next    = '0;
                    seen_next   = 1'b0;
                    offset_next = '0;
                end
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (result_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
            open_reg    <= 1'b0;
            pos_reg     <= '0;
            seen_reg    <= 1'b0;
            offset_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            ovf_reg     <= ovf_next;
            open_reg    <= open_next;
            pos_reg     <= pos_next;
            seen_reg    <= seen_next;
            offset_reg  <= offset_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (result_load) begin
            found_reg  <= found_next;
            index_reg  <= index_next;
            status_reg <= status_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(M_TDATA_W - 1 - IDX_W - STATUS_W)'(0), status_reg, index_reg, found_reg};

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_LIMIT)
        else $error("needle length beyond cell count");

    a_occ_count: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(occ_chain) == int'(count_reg))
        else $error("occupied cells disagree with needle length");

    a_found_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && found_reg |-> status_reg == STATUS_OK)
        else $error("found reported with error status");

    a_offset_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        seen_reg |-> (CMP_W + 1)'(offset_reg) + (CMP_W + 1)'(count_reg)
                     <= (CMP_W + 1)'(pos_reg))
        else $error("match offset beyond haystack position");

    a_result_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && req_type == REQ_HAY && s_tlast |=> m_valid_reg)
        else $error("haystack end gave no result");

endmodule
`default_nettype wire

// ===== tb/byte_substring_first_match_tb.sv =====
module byte_substring_first_match_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bsfm_pkg::*;

    typedef struct packed {
        logic                found;
        logic [IDX_W-1:0]    offset;
        logic [STATUS_W-1:0] status;
    } search_outcome_t;

    class search_checker;
        byte_t                 needle_bytes[MAX_NEEDLE];
        logic [CNT_W-1:0]      needle_len;
        bit                    needle_spill;
        bit                    needle_loading;
        byte_t                 window[MAX_NEEDLE];
        logic [HAY_POS_W-1:0]  hay_pos;
        bit                    hit_seen;
        logic [IDX_W-1:0]      hit_at;
        search_outcome_t       outcomes[$];
        int                    errors;

        function new();
            foreach (needle_bytes[i]) needle_bytes[i] = '0;
            needle_len     = '0;
            needle_spill   = 1'b0;
            needle_loading = 1'b0;
            errors         = 0;
            restart_haystack();
        endfunction

        function void restart_haystack();
            foreach (window[i]) window[i] = '0;
            hay_pos  = '0;
            hit_seen = 1'b0;
            hit_at   = '0;
        endfunction

        function bit window_holds_needle();
            int i;
            for (i = 0; i < needle_len; i++) begin
                if (needle_bytes[i] != window[needle_len - 1 - i]) return 1'b0;
            end
            return 1'b1;
        endfunction

        function int pending();
            return outcomes.size();
        endfunction

        function void note_item(logic req, byte_t b, logic has, logic last);
            int                   i;
            logic [HAY_POS_W-1:0] span;
            search_outcome_t      res;
            if (req == REQ_NEEDLE) begin
                restart_haystack();
                if (!needle_loading) begin
                    needle_len     = '0;
                    needle_spill   = 1'b0;
                    needle_loading = 1'b1;
                end
                if (has) begin
                    if (needle_len < MAX_NEEDLE) begin
                        needle_bytes[needle_len] = b;
                        needle_len++;
                    end else begin
                        needle_spill = 1'b1;
                    end
                end
                if (last) needle_loading = 1'b0;
                return;
            end
            needle_loading = 1'b0;
            if (has) begin
                for (i = MAX_NEEDLE - 1; i > 0; i--) window[i] = window[i-1];
                window[0] = b;
                if (hay_pos <= MAX_HAYSTACK) hay_pos++;
                if (!hit_seen && hay_pos <= MAX_HAYSTACK && needle_len != 0 &&
                    hay_pos >= needle_len && window_holds_needle()) begin
                    hit_seen = 1'b1;
                    hit_at   = IDX_W'(hay_pos - needle_len);
                end
            end
            if (!last) return;
            span = (hay_pos > MAX_HAYSTACK) ? HAY_POS_W'(MAX_HAYSTACK) : hay_pos;
            res.status = STATUS_OK;
            res.found  = 1'b0;
            res.offset = IDX_W'(span);
            if (needle_spill) begin
                res.status = STATUS_NEEDLE_LONG;
            end else if (hay_pos > MAX_HAYSTACK) begin
                res.status = STATUS_HAY_LONG;
                res.offset = IDX_W'(MAX_HAYSTACK);
            end else if (needle_len == 0) begin
                res.found  = 1'b1;
                res.offset = '0;
            end else if (hit_seen) begin
                res.found  = 1'b1;
                res.offset = hit_at;
            end
            outcomes.push_back(res);
            restart_haystack();
        endfunction

        function void check_outcome(logic [M_TDATA_W-1:0] t);
            search_outcome_t want;
            logic                got_found;
            logic [IDX_W-1:0]    got_offset;
            logic [STATUS_W-1:0] got_status;
            got_found  = t[0];
            got_offset = t[IDX_W:1];
            got_status = t[IDX_W+STATUS_W:IDX_W+1];
            if (outcomes.size() == 0) begin
                $display("%0t: result with none outstanding, expected nothing, actual %h",
                         $time, t);
                errors++;
                return;
            end
            want = outcomes.pop_front();
            if (got_found !== want.found) begin
                $display("%0t: found expected %0d actual %0d", $time, want.found, got_found);
                errors++;
            end
            if (got_offset !== want.offset) begin
                $display("%0t: match_index expected %0d actual %0d",
                         $time, want.offset, got_offset);
                errors++;
            end
            if (got_status !== want.status) begin
                $display("%0t: status expected %0d actual %0d",
                         $time, want.status, got_status);
                errors++;
            end
        endfunction
    endclass

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tuser  = 1'b0;
    logic                 s_tlast  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    search_checker chk;
    int            items_sent = 0;
    bit            gaps_on    = 1'b1;
    byte_t         cur_needle[$];
    byte_t         hay_buf[$];
    int            sym_range  = 0;
    byte_t         sym_flip   = '0;

    byte_substring_first_match u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #4 aclk = ~aclk;

    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(13, 40);
    endfunction

    function automatic byte_t pick_byte();
        if (sym_range == 0) return byte_t'($urandom);
        return byte_t'($urandom_range(0, sym_range)) ^ sym_flip;
    endfunction

    task automatic new_symbols();
        sym_range = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 3);
        sym_flip  = byte_t'($urandom);
    endtask

    task automatic send_item(input logic req, input byte_t b, input logic has,
                             input logic last);
        int gap;
        gap = gaps_on ? idle_length() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tlast  <= last;
        s_tdata  <= {{(S_TDATA_W-9){1'b0}}, has, b};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        chk.note_item(req, b, has, last);
        items_sent++;
    endtask

    task automatic send_run(input logic req, input byte_t q[$], input bit plain);
        bit marker_end;
        marker_end = !plain && ($urandom_range(0, 6) == 0);
        foreach (q[i]) begin
            if (!plain && $urandom_range(0, 19) == 0)
                send_item(req, byte_t'($urandom), 1'b0, 1'b0);
            send_item(req, q[i], 1'b1, (i == q.size() - 1) && !marker_end);
        end
        if (marker_end || q.size() == 0) send_item(req, byte_t'($urandom), 1'b0, 1'b1);
    endtask

    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        while (chk.pending() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic make_needle();
        int r;
        int n;
        r = $urandom_range(0, 99);
        if (r < 5) n = 0;
        else if (r < 75) n = $urandom_range(1, 4);
        else if (r < 93) n = $urandom_range(5, MAX_NEEDLE);
        else n = $urandom_range(MAX_NEEDLE + 1, MAX_NEEDLE + 4);
        new_symbols();
        cur_needle.delete();
        repeat (n) cur_needle.push_back(pick_byte());
        send_run(REQ_NEEDLE, cur_needle, 1'b0);
    endtask

    task automatic fill_haystack(input int len);
        int n;
        int at;
        int i;
        hay_buf.delete();
        repeat (len) hay_buf.push_back(pick_byte());
        n = cur_needle.size();
        if (n > 0 && n <= len && $urandom_range(0, 1) == 1) begin
            at = $urandom_range(0, len - n);
            for (i = 0; i < n; i++) hay_buf[at + i] = cur_needle[i];
        end
    endtask

    task automatic search_round();
        int reps;
        if (cur_needle.size() == 0 || $urandom_range(0, 2) != 0) make_needle();
        reps = $urandom_range(1, 3);
        repeat (reps) begin
            fill_haystack(($urandom_range(0, 9) == 0) ? $urandom_range(31, 80)
                                                      : $urandom_range(0, 30));
            send_run(REQ_HAY, hay_buf, 1'b0);
        end
    endtask

    task automatic cut_short();
        int    k;
        byte_t b;
        k = $urandom_range(1, 10);
        if ($urandom_range(0, 1) == 0) begin
            cur_needle.delete();
            repeat ((k + 2) / 3) begin
                b = pick_byte();
                cur_needle.push_back(b);
                send_item(REQ_NEEDLE, b, 1'b1, 1'b0);
            end
            fill_haystack($urandom_range(0, 20));
            send_run(REQ_HAY, hay_buf, 1'b0);
        end else begin
            repeat (k) send_item(REQ_HAY, pick_byte(), 1'b1, 1'b0);
            make_needle();
        end
    endtask

    task automatic stray_items();
        repeat ($urandom_range(1, 8))
            send_item(logic'($urandom_range(0, 1)), byte_t'($urandom),
                      logic'($urandom_range(0, 1)), logic'($urandom_range(0, 1)));
    endtask

    initial begin
        int    stall;
        int    run;
        @(posedge aclk);
        forever begin
            stall = idle_length();
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            run = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 100) : $urandom_range(1, 4);
            repeat (run) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) chk.check_outcome(m_tdata);
    end

    initial begin
        #10_000_000;
        $display("FAIL");
        $finish;
    end

    initial begin
        byte_t q[$];
        int    i;
        int    target;
        int    r;
        chk = new();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        q.delete();
        send_run(REQ_HAY, q, 1'b1);
        q = '{8'h00, 8'hFF};
        send_run(REQ_NEEDLE, q, 1'b1);
        q = '{8'hFF, 8'h00, 8'hFF};
        send_run(REQ_HAY, q, 1'b1);
        q = '{8'h00};
        send_run(REQ_HAY, q, 1'b1);
        q.delete();
        send_run(REQ_NEEDLE, q, 1'b1);
        q = '{8'hAA, 8'h55};
        send_run(REQ_HAY, q, 1'b1);
        send_item(REQ_NEEDLE, 8'h12, 1'b1, 1'b0);
        send_item(REQ_HAY, 8'h12, 1'b1, 1'b1);
        send_item(REQ_NEEDLE, 8'h34, 1'b1, 1'b1);
        send_item(REQ_HAY, 8'h00, 1'b1, 1'b0);
        send_item(REQ_HAY, 8'h34, 1'b1, 1'b0);
        send_item(REQ_NEEDLE, 8'h00, 1'b0, 1'b0);
        send_item(REQ_NEEDLE, 8'h34, 1'b1, 1'b1);
        send_item(REQ_HAY, 8'hC3, 1'b0, 1'b0);
        send_item(REQ_HAY, 8'h34, 1'b1, 1'b0);
        send_item(REQ_HAY, 8'h5E, 1'b0, 1'b1);

        hold_until_drained();

        q.delete();
        for (i = 0; i < MAX_NEEDLE; i++) q.push_back(byte_t'($urandom));
        send_run(REQ_NEEDLE, q, 1'b1);
        for (i = 0; i < 3; i++) q.push_front(byte_t'($urandom));
        q.push_back(byte_t'($urandom));
        send_run(REQ_HAY, q, 1'b1);
        q.delete();
        for (i = 0; i < MAX_NEEDLE + 2; i++) q.push_back(byte_t'($urandom));
        send_run(REQ_NEEDLE, q, 1'b1);
        q = '{8'h01, 8'h80, 8'h7F, 8'hFE, 8'h00};
        send_run(REQ_HAY, q, 1'b1);
        q.delete();

        target = 1450;
        while (items_sent < target) begin
            gaps_on = ($urandom_range(0, 4) != 0);
            r = $urandom_range(0, 99);
            if (r < 3) hold_until_drained();
            else if (r < 72) search_round();
            else if (r < 87) cut_short();
            else stray_items();
        end

        s_tvalid <= 1'b0;
        while (chk.pending() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (chk.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== byte_substring_first_match.f =====
hdl/bsfm_pkg.sv
hdl/bsfm_cell.sv
hdl/byte_substring_first_match.sv
tb/byte_substring_first_match_tb.sv
